### hdl/chrs_pkg.sv
package chrs_pkg;

  localparam int OUT_W      = 36;
  localparam int WGT_IN_W   = 16;
  localparam int CH_W       = 8;
  localparam int COORD_W    = 10;
  localparam int SEL_W      = 3;
  localparam int BIN_IN_W   = 9;
  localparam int CFG_W      = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int THR_W      = 16;
  // class tables named by table_select
  localparam int CLS_COUNT  = 6;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [SEL_W-1:0] CLS_GROUND    = 3'd0;
  localparam logic [SEL_W-1:0] CLS_PITCH     = 3'd1;
  localparam logic [SEL_W-1:0] CLS_SKY       = 3'd2;
  localparam logic [SEL_W-1:0] CLS_SCORECARD = 3'd3;
  localparam logic [SEL_W-1:0] CLS_TEAM_A    = 3'd4;
  localparam logic [SEL_W-1:0] CLS_TEAM_B    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORECARD_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SC_ROW_FIRST     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SC_ROW_LAST      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SC_COL_FIRST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SC_COL_LAST      = 3'd5;

  localparam logic [THR_W-1:0]   RST_WEIGHT_THRESHOLD = 16'd916;
  localparam logic [OUT_W-1:0]   RST_SCORECARD_LIMIT  = 36'd16384000;
  localparam logic [COORD_W-1:0] RST_SC_ROW_FIRST     = 10'd309;
  localparam logic [COORD_W-1:0] RST_SC_ROW_LAST      = 10'd344;
  localparam logic [COORD_W-1:0] RST_SC_COL_FIRST     = 10'd129;
  localparam logic [COORD_W-1:0] RST_SC_COL_LAST      = 10'd225;

  typedef struct packed {
    logic                req_type;
    logic [SEL_W-1:0]    table_select;
    logic [BIN_IN_W-1:0] bin_index;
    logic [WGT_IN_W-1:0] weight;
    logic [CH_W-1:0]     red;
    logic [CH_W-1:0]     green;
    logic [CH_W-1:0]     blue;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
    logic                frame_end;
  } req_t;

  typedef struct packed {
    logic [OUT_W-1:0] ground_total;
    logic [OUT_W-1:0] pitch_total;
    logic [OUT_W-1:0] sky_total;
    logic [OUT_W-1:0] card_total;
    logic             scorecard_absent;
    logic [OUT_W-1:0] team_a_score;
    logic [OUT_W-1:0] team_b_score;
  } res_t;

endpackage

### hdl/color_histogram_region_scorer_unit.sv
// channel | dir | handshake             | payload
// cfg     | in  | cfg_we                | cfg_index, cfg_data
// req     | in  | req_valid / req_stall | req (req_t): weight load or pixel
// res     | out | res_valid / res_stall | res (res_t): frame scores
//
// One item per clock while req_stall is low. A pixel reads all class tables at
// the edge that takes it (registered RAM read); the sums and the result register
// both load when the sum stage fires, and a frame_end pixel there raises res_valid.
// req_stall rises only while a frame result sits in the sum stage and the
// result register is full and stalled.
// Synchronous reset clears sums and valids and restores config defaults; table
// contents stay undefined until loaded.
module color_histogram_region_scorer_unit
  import chrs_pkg::*;
#(
  parameter int WEIGHT_BITS   = 16,
  parameter int SUM_BITS      = 36,
  parameter int MAIN_ROW_LAST = 350,
  parameter int MAIN_COL_LAST = 630,
  parameter int NUM_CLASSES   = 6,
  parameter int NUM_BINS      = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  localparam int BIN_AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int WCMP_W  = (WEIGHT_BITS > THR_W) ? WEIGHT_BITS : THR_W;
  localparam int CMP_W   = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;

  function automatic logic [OUT_W-1:0] clamp_out(input logic [SUM_BITS-1:0] v);
    logic [CMP_W-1:0] e;
    e = CMP_W'(v);
    return (e > CMP_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
  endfunction

  // configuration
  logic [THR_W-1:0]   weight_threshold;
  logic [OUT_W-1:0]   scorecard_limit;
  logic [COORD_W-1:0] sc_row_first, sc_row_last, sc_col_first, sc_col_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_threshold <= RST_WEIGHT_THRESHOLD;
      scorecard_limit  <= RST_SCORECARD_LIMIT;
      sc_row_first     <= RST_SC_ROW_FIRST;
      sc_row_last      <= RST_SC_ROW_LAST;
      sc_col_first     <= RST_SC_COL_FIRST;
      sc_col_last      <= RST_SC_COL_LAST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_THRESHOLD: weight_threshold <= cfg_data[THR_W-1:0];
        REG_SCORECARD_LIMIT:  scorecard_limit  <= cfg_data[OUT_W-1:0];
        REG_SC_ROW_FIRST:     sc_row_first     <= cfg_data[COORD_W-1:0];
        REG_SC_ROW_LAST:      sc_row_last      <= cfg_data[COORD_W-1:0];
        REG_SC_COL_FIRST:     sc_col_first     <= cfg_data[COORD_W-1:0];
        REG_SC_COL_LAST:      sc_col_last      <= cfg_data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  logic                hold;
  logic                accept, pix_accept, load_ok;
  logic [BIN_IN_W-1:0] pix_bin;
  logic                pix_bin_ok, in_main, in_sc;

  assign req_stall  = hold;
  assign accept     = req_valid && !req_stall;
  assign pix_accept = accept && (req.req_type == REQ_PIXEL);
  assign load_ok    = accept && (req.req_type == REQ_LOAD) &&
                      (int'(req.bin_index) < NUM_BINS);
  assign pix_bin    = {req.blue[CH_W-1 -: 3], req.green[CH_W-1 -: 3], req.red[CH_W-1 -: 3]};
  assign pix_bin_ok = int'(pix_bin) < NUM_BINS;
  assign in_main    = (req.row != '0) && (req.row <= COORD_W'(MAIN_ROW_LAST)) &&
                      (req.column != '0) && (req.column <= COORD_W'(MAIN_COL_LAST));
  assign in_sc      = (req.row >= sc_row_first) && (req.row <= sc_row_last) &&
                      (req.column >= sc_col_first) && (req.column <= sc_col_last);

  logic [WEIGHT_BITS-1:0] rd_data [CLS_COUNT];

  for (genvar k = 0; k < CLS_COUNT; k++) begin : g_tbl
    if (k < NUM_CLASSES) begin : g_ram
      chrs_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NUM_BINS)
      ) u_ram (
        .clk   (clk),
        .we    (load_ok && (req.table_select == SEL_W'(k))),
        .waddr (BIN_AW'(req.bin_index)),
        .wdata (WEIGHT_BITS'(req.weight)),
        .re    (pix_accept),
        .raddr (BIN_AW'(pix_bin)),
        .rdata (rd_data[k])
      );
    end else begin : g_none
      assign rd_data[k] = '0;
    end
  end

  // sum stage
  logic s1_valid, s1_pixel, s1_main, s1_sc, s1_bin_ok, s1_fe;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pixel  <= req.req_type == REQ_PIXEL;
      s1_main   <= in_main;
      s1_sc     <= in_sc;
      s1_bin_ok <= pix_bin_ok;
      s1_fe     <= req.frame_end;
    end
  end

  logic s1_fire, s1_result;

  assign hold      = s1_valid && s1_pixel && s1_fe && res_valid && res_stall;
  assign s1_fire   = s1_valid && !hold;
  assign s1_result = s1_fire && s1_pixel && s1_fe;

  logic [SUM_BITS-1:0] sums      [CLS_COUNT];
  logic [SUM_BITS-1:0] sums_next [CLS_COUNT];

  always_comb begin
    logic [WEIGHT_BITS-1:0] w;
    logic [SUM_BITS:0]      sx;
    logic                   hit;
    for (int k = 0; k < CLS_COUNT; k++) begin
      w  = s1_bin_ok ? rd_data[k] : '0;
      sx = {1'b0, sums[k]} + (SUM_BITS+1)'(w);
      if (k == int'(CLS_SCORECARD)) begin
        hit = s1_sc && (w != '0);
      end else begin
        hit = s1_main && (WCMP_W'(w) > WCMP_W'(weight_threshold));
      end
      if (!hit) begin
        sums_next[k] = sums[k];
      end else if (sx[SUM_BITS]) begin
        sums_next[k] = '1;
      end else begin
        sums_next[k] = sx[SUM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CLS_COUNT; k++) begin
        sums[k] <= '0;
      end
    end else if (s1_fire && s1_pixel) begin
      for (int k = 0; k < CLS_COUNT; k++) begin
        sums[k] <= s1_fe ? '0 : sums_next[k];
      end
    end
  end

  // result register
  res_t res_next;

  always_comb begin
    res_next.ground_total     = clamp_out(sums_next[CLS_GROUND]);
    res_next.pitch_total      = clamp_out(sums_next[CLS_PITCH]);
    res_next.sky_total        = clamp_out(sums_next[CLS_SKY]);
    res_next.card_total       = clamp_out(sums_next[CLS_SCORECARD]);
    res_next.scorecard_absent = CMP_W'(sums_next[CLS_SCORECARD]) <= CMP_W'(scorecard_limit);
    res_next.team_a_score     = clamp_out(sums_next[CLS_TEAM_A]);
    res_next.team_b_score     = clamp_out(sums_next[CLS_TEAM_B]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      res_valid <= s1_result;
    end
    if (s1_result) begin
      res <= res_next;
    end
  end

endmodule

### hdl/chrs_ram.sv
module chrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/chrs_checker.sv
module chrs_checker
  import chrs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input req_t                 req,
  input logic                 res_valid,
  input logic                 res_stall,
  input res_t                 res
);

  logic acc_fe;

  assign acc_fe = req_valid && !req_stall && (req.req_type == REQ_PIXEL) && req.frame_end;

  // a waiting result holds still
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // frame end pixel yields a result through the sum stage and result register (held if stalled)
  a_fe_result: assert property (@(posedge clk) disable iff (rst)
    acc_fe |-> ##2 res_valid)
    else $error("frame end produced no result");

  // no result out of nowhere
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(acc_fe, 2))
    else $error("result without a frame end pixel");

endmodule

bind color_histogram_region_scorer_unit chrs_checker u_chrs_checker (.*);
